// File: sv/assert_macros.svh
// Assertion macros used by the RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: sv/sinl_pkg.sv
// Shared constants and types for the sorted interval lookup block.
package sinl_pkg;

    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_VALUE_BITS  = 64;

    localparam int FIELD_BITS  = 64;
    localparam int IN_BITS     = 3 * FIELD_BITS;
    localparam int KIND_BITS   = 2;
    localparam int STATUS_BITS = 3;
    localparam int INDEX_BITS  = 10;
    localparam int OUT_BITS    = 16;

    typedef logic [KIND_BITS-1:0]   kind_t;
    typedef logic [STATUS_BITS-1:0] status_t;
    typedef logic [INDEX_BITS-1:0]  index_t;

    localparam kind_t KIND_CLEAR  = 2'd0;
    localparam kind_t KIND_APPEND = 2'd1;
    localparam kind_t KIND_QUERY  = 2'd2;

    localparam status_t STATUS_OK          = 3'd0;
    localparam status_t STATUS_INVALID     = 3'd1;
    localparam status_t STATUS_BAD_COUNT   = 3'd2;
    localparam status_t STATUS_MEMBER      = 3'd3;
    localparam status_t STATUS_NO_STRADDLE = 3'd4;
    localparam status_t STATUS_FULL        = 3'd5;

endpackage

// File: sv/sorted_interval_nonmember_lookup_top.sv
// Sorted interval table with append checks and non-membership lookup.
// One request is worked on at a time. A clear, an append or an unused kind passes from the
// work state through the pending state to the output register. A query on a valid table
// with a power-of-two record count scans the record memory through its single read port,
// one record a cycle, first for a stored value equal to the target and then for the first
// straddling record, and ends early on a hit. A new request is taken once the previous
// result is in the output register, even if that result has not been taken yet. The memory
// needs no clearing pass after reset; only entries below the record count are ever used.
`include "assert_macros.svh"

module sorted_interval_nonmember_lookup_top
    import sinl_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // entry_value[63:0], entry_next_value[127:64], query_target[191:128]
    input  logic [IN_BITS-1:0]  s_axis_tdata,
    // kind[1:0]
    input  logic [KIND_BITS-1:0] s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // status[2:0], adjacent_index[12:3], zero[15:13]
    output logic [OUT_BITS-1:0] m_axis_tdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int VB = VALUE_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WORK = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_PEND = 2'd3;

    logic [2*VB-1:0] mem [TABLE_DEPTH];
    logic [2*VB-1:0] rdata_reg;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [VB-1:0] last_val_reg, last_val_next;
    logic [VB-1:0] last_nxt_reg, last_nxt_next;
    logic          bad_reg, bad_next;
    logic          phase_reg, phase_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          chk_valid_reg, chk_valid_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next;
    logic          out_valid_reg, out_valid_next;
    status_t       out_status_reg, out_status_next;
    index_t        out_idx_reg, out_idx_next;

    kind_t         kind_reg, kind_next;
    logic [VB-1:0] val_reg, val_next;
    logic [VB-1:0] nxt_reg, nxt_next;
    logic [VB-1:0] tgt_reg, tgt_next;
    status_t       pend_status_reg, pend_status_next;
    index_t        pend_idx_reg, pend_idx_next;

    logic          accept;
    logic          full;
    logic          pow2;
    logic          issuing;
    logic          mem_we;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic [VB-1:0] r_val;
    logic [VB-1:0] r_nxt;
    logic          chk_last;
    logic          bad_append;
    logic          out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_idx_reg, out_status_reg};
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign full     = (count_reg >= CW'(TABLE_DEPTH));
    assign pow2     = (count_reg != '0) && ((count_reg & (count_reg - 1'b1)) == '0);
    assign issuing  = (state_reg == ST_SCAN) && (issue_reg < count_reg);
    assign rd_addr  = issue_reg[AW-1:0];
    assign wr_addr  = count_reg[AW-1:0];
    assign r_val    = rdata_reg[VB-1:0];
    assign r_nxt    = rdata_reg[2*VB-1:VB];
    assign chk_last = (CW'(chk_idx_reg) == (count_reg - 1'b1));
    assign mem_we   = (state_reg == ST_WORK) && (kind_reg == KIND_APPEND) && !full;

    assign bad_append = (val_reg > nxt_reg)
                     || ((count_reg != '0)
                         && ((last_val_reg > val_reg)
                             || ((last_val_reg < last_nxt_reg) && (last_nxt_reg > val_reg))));

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        last_val_next    = last_val_reg;
        last_nxt_next    = last_nxt_reg;
        bad_next         = bad_reg;
        phase_next       = phase_reg;
        issue_next       = issue_reg;
        chk_valid_next   = 1'b0;
        chk_idx_next     = chk_idx_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_status_next  = out_status_reg;
        out_idx_next     = out_idx_reg;
        kind_next        = kind_reg;
        val_next         = val_reg;
        nxt_next         = nxt_reg;
        tgt_next         = tgt_reg;
        pend_status_next = pend_status_reg;
        pend_idx_next    = pend_idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = s_axis_tuser;
                    val_next   = s_axis_tdata[VB-1:0];
                    nxt_next   = s_axis_tdata[FIELD_BITS+VB-1:FIELD_BITS];
                    tgt_next   = s_axis_tdata[2*FIELD_BITS+VB-1:2*FIELD_BITS];
                    state_next = ST_WORK;
                end
            end
            ST_WORK:
            begin
                pend_status_next = STATUS_OK;
                pend_idx_next    = '0;
                state_next       = ST_PEND;
                unique case (kind_reg)
                    KIND_CLEAR:
                    begin
                        count_next    = '0;
                        last_val_next = '0;
                        last_nxt_next = '0;
                        bad_next      = 1'b0;
                    end
                    KIND_APPEND:
                    begin
                        if (full)
                        begin
                            pend_status_next = STATUS_FULL;
                        end
                        else
                        begin
                            bad_next         = bad_reg || bad_append;
                            count_next       = count_reg + 1'b1;
                            last_val_next    = val_reg;
                            last_nxt_next    = nxt_reg;
                            pend_status_next = (bad_reg || bad_append) ? STATUS_INVALID
                                                                       : STATUS_OK;
                        end
                    end
                    KIND_QUERY:
                    begin
                        if (bad_reg)
                        begin
                            pend_status_next = STATUS_INVALID;
                        end
                        else if (!pow2)
                        begin
                            pend_status_next = STATUS_BAD_COUNT;
                        end
                        else
                        begin
                            phase_next = 1'b0;
                            issue_next = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    default:
                    begin
                        pend_status_next = STATUS_OK;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (issuing)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = issue_reg[AW-1:0];
                    issue_next     = issue_reg + 1'b1;
                end
                if (chk_valid_reg)
                begin
                    if (!phase_reg)
                    begin
                        if (r_val == tgt_reg)
                        begin
                            pend_status_next = STATUS_MEMBER;
                            pend_idx_next    = '0;
                            chk_valid_next   = 1'b0;
                            state_next       = ST_PEND;
                        end
                        else if (chk_last)
                        begin
                            phase_next     = 1'b1;
                            issue_next     = '0;
                            chk_valid_next = 1'b0;
                        end
                    end
                    else
                    begin
                        if ((r_val < tgt_reg) && (tgt_reg < r_nxt))
                        begin
                            pend_status_next = STATUS_OK;
                            pend_idx_next    = INDEX_BITS'(chk_idx_reg);
                            chk_valid_next   = 1'b0;
                            state_next       = ST_PEND;
                        end
                        else if (chk_last)
                        begin
                            pend_status_next = STATUS_NO_STRADDLE;
                            pend_idx_next    = '0;
                            chk_valid_next   = 1'b0;
                            state_next       = ST_PEND;
                        end
                    end
                end
            end
            ST_PEND:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_idx_next    = pend_idx_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            last_val_reg  <= '0;
            last_nxt_reg  <= '0;
            bad_reg       <= 1'b0;
            phase_reg     <= 1'b0;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            last_val_reg  <= last_val_next;
            last_nxt_reg  <= last_nxt_next;
            bad_reg       <= bad_next;
            phase_reg     <= phase_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg     <= chk_idx_next;
        out_status_reg  <= out_status_next;
        out_idx_reg     <= out_idx_next;
        kind_reg        <= kind_next;
        val_reg         <= val_next;
        nxt_reg         <= nxt_next;
        tgt_reg         <= tgt_next;
        pend_status_reg <= pend_status_next;
        pend_idx_reg    <= pend_idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= {nxt_reg, val_reg};
        end
        rdata_reg <= mem[rd_addr];
    end

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CW'(TABLE_DEPTH))
    `ASSERT_IMPLIES(a_chk_in_scan, clk, rst_n, chk_valid_reg, state_reg == ST_SCAN)
    `ASSERT_NEXT(a_accept_to_work, clk, rst_n, accept, state_reg == ST_WORK)
    `ASSERT_IMPLIES(a_out_from_pend, clk, rst_n, $rose(out_valid_reg),
        $past(state_reg) == ST_PEND)
    `ASSERT_IMPLIES(a_scan_pow2, clk, rst_n, state_reg == ST_SCAN, pow2 && !bad_reg)

endmodule

// File: tb/tb_sorted_interval_nonmember_lookup_top.sv
// Self-checking testbench for the sorted interval non-membership lookup block.
module tb_sorted_interval_nonmember_lookup_top
    import sinl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int    DEPTH        = DEF_TABLE_DEPTH;
    localparam int    LIMIT_CYCLES = 600000;
    localparam int    HOLD_CYCLES  = 400;
    localparam kind_t KIND_UNUSED  = 2'd3;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct {
        kind_t       kind;
        logic [63:0] entry_value;
        logic [63:0] entry_next;
        logic [63:0] target;
    } request_t;

    typedef struct {
        status_t status;
        index_t  index;
    } answer_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_BITS-1:0]   s_axis_tdata = '0;
    logic [KIND_BITS-1:0] s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0]  m_axis_tdata;

    request_t pending_reqs[$];
    answer_t  expected_answers[$];
    request_t cur_req;
    bit       req_taken = 1'b0;

    logic [63:0] rec_value [DEPTH];
    logic [63:0] rec_next [DEPTH];
    int          rec_count = 0;
    logic [63:0] tail_value = '0;
    logic [63:0] tail_next = '0;
    bit          table_bad = 1'b0;

    logic [63:0] set_value[$];
    logic [63:0] set_next[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_req = 1'b0;
    int hold_left = 0;

    int n_pushed = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_errors = 0;
    int status_hits[8];
    int cycles = 0;

    sorted_interval_nonmember_lookup_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic answer_t lookup_answer(request_t r);
        answer_t a;
        bit      found;
        a.status = STATUS_OK;
        a.index  = '0;
        found    = 1'b0;
        case (r.kind)
            KIND_CLEAR:
            begin
                rec_count  = 0;
                tail_value = '0;
                tail_next  = '0;
                table_bad  = 1'b0;
            end
            KIND_APPEND:
            begin
                if (rec_count >= DEPTH)
                begin
                    a.status = STATUS_FULL;
                end
                else
                begin
                    if (r.entry_value > r.entry_next)
                        table_bad = 1'b1;
                    if (rec_count > 0)
                    begin
                        if (tail_value > r.entry_value)
                            table_bad = 1'b1;
                        if (tail_value < tail_next && tail_next > r.entry_value)
                            table_bad = 1'b1;
                    end
                    rec_value[rec_count] = r.entry_value;
                    rec_next[rec_count]  = r.entry_next;
                    rec_count++;
                    tail_value = r.entry_value;
                    tail_next  = r.entry_next;
                    a.status   = table_bad ? STATUS_INVALID : STATUS_OK;
                end
            end
            KIND_QUERY:
            begin
                if (table_bad)
                    a.status = STATUS_INVALID;
                else if (rec_count == 0 || (rec_count & (rec_count - 1)) != 0)
                    a.status = STATUS_BAD_COUNT;
                else
                begin
                    for (int i = 0; i < rec_count && !found; i++)
                        if (rec_value[i] == r.target)
                        begin
                            a.status = STATUS_MEMBER;
                            found    = 1'b1;
                        end
                    for (int i = 0; i < rec_count && !found; i++)
                        if (rec_value[i] < r.target && r.target < rec_next[i])
                        begin
                            a.index = index_t'(i);
                            found   = 1'b1;
                        end
                    if (!found)
                        a.status = STATUS_NO_STRADDLE;
                end
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    task automatic push_req(kind_t kind, logic [63:0] v, logic [63:0] nv, logic [63:0] t);
        request_t r;
        r.kind        = kind;
        r.entry_value = v;
        r.entry_next  = nv;
        r.target      = t;
        pending_reqs.push_back(r);
        n_pushed++;
    endtask

    task automatic queue_clear();
        push_req(KIND_CLEAR, rand64(), rand64(), rand64());
    endtask

    task automatic queue_append(logic [63:0] v, logic [63:0] nv);
        push_req(KIND_APPEND, v, nv, rand64());
    endtask

    task automatic queue_query(logic [63:0] t);
        push_req(KIND_QUERY, rand64(), rand64(), t);
    endtask

    task automatic queue_unused();
        push_req(KIND_UNUSED, rand64(), rand64(), rand64());
    endtask

    // Build a clean sorted, non-overlapping set of n records and append it after a clear.
    task automatic queue_set(int n);
        logic [63:0] slot;
        logic [63:0] v;
        logic [63:0] nv;
        int          mode;
        set_value.delete();
        set_next.delete();
        slot = ALL_ONES / 64'(n);
        for (int i = 0; i < n; i++)
        begin
            v = 64'(i) * slot + (rand64() % (slot / 2 + 1));
            if (i == 0 && $urandom_range(3) == 0)
                v = '0;
            set_value.push_back(v);
        end
        for (int i = 0; i < n; i++)
        begin
            mode = $urandom_range(3);
            v    = set_value[i];
            case (mode)
                0:       nv = v;
                1:       nv = v + (rand64() % (slot / 2));
                2:       nv = (i == n - 1) ? ALL_ONES : set_value[i + 1];
                default: nv = (i == n - 1) ? ALL_ONES : 64'(i + 1) * slot;
            endcase
            set_next.push_back(nv);
        end
        queue_clear();
        for (int i = 0; i < n; i++)
            queue_append(set_value[i], set_next[i]);
    endtask

    function automatic logic [63:0] pick_target();
        int          r;
        logic [63:0] lo;
        logic [63:0] hi;
        r  = $urandom_range(set_value.size() - 1);
        lo = set_value[r];
        hi = set_next[r];
        case ($urandom_range(6))
            0:       return lo;
            1, 2:    return (hi > lo + 1) ? lo + 1 + (rand64() % (hi - lo - 1)) : rand64();
            3:       return hi;
            4:       return lo - 1;
            5:       return $urandom_range(1) ? ALL_ONES : 64'd0;
            default: return rand64();
        endcase
    endfunction

    task automatic wait_drained();
        while (n_pushed != n_accepted || expected_answers.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
    begin : drive_req
        request_t nxt;
        if (rst_n && !(s_axis_tvalid && !req_taken))
        begin
            req_taken = 1'b0;
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt     = pending_reqs.pop_front();
                cur_req = nxt;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {nxt.target, nxt.entry_next, nxt.entry_value};
                s_axis_tuser  <= nxt.kind;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : drive_ready
        if (hold_req)
        begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : watch
        answer_t got;
        answer_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_answers.push_back(lookup_answer(cur_req));
                req_taken = 1'b1;
                n_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status = m_axis_tdata[2:0];
                got.index  = m_axis_tdata[12:3];
                n_results++;
                status_hits[got.status]++;
                if (expected_answers.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: unexpected result status %0d index %0d",
                             $time, got.status, got.index);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (got.status !== want.status)
                    begin
                        n_errors++;
                        $display("%0t: status mismatch expected %0d actual %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.index !== want.index)
                    begin
                        n_errors++;
                        $display("%0t: adjacent_index mismatch expected %0d actual %0d",
                                 $time, want.index, got.index);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_answers.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase_items;
        int n;
        int idle_send[4];
        int idle_recv[4];
        idle_send = '{0, 51, 0, 20};
        idle_recv = '{0, 0, 51, 20};
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty table, unused kind, degenerate and full-range records, bad counts, invalid appends
        queue_query(64'd0);
        queue_unused();
        queue_append(64'd0, 64'd0);
        queue_query(64'd0);
        queue_query(64'd5);
        queue_clear();
        queue_append(64'd0, ALL_ONES);
        queue_query(ALL_ONES);
        queue_query(64'd1);
        queue_clear();
        queue_append(64'd0, 64'd100);
        queue_append(64'd100, 64'd200);
        queue_query(64'd150);
        queue_query(64'd100);
        queue_query(64'd200);
        queue_append(64'd300, 64'd250);
        queue_query(64'd260);
        queue_clear();
        queue_append(64'd50, 64'd60);
        queue_append(64'd40, 64'd70);
        queue_clear();
        queue_append(64'd5, 64'd5);
        queue_append(64'd5, 64'd9);
        queue_query(64'd7);
        queue_append(ALL_ONES, ALL_ONES);
        queue_query(64'd7);
        queue_clear();
        queue_append(64'd10, 64'd100);
        queue_append(64'd50, 64'd200);
        queue_query(64'd60);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_send[p];
            recv_stall_pct = idle_recv[p];
            phase_items    = n_pushed;
            while (n_pushed - phase_items < 48)
            begin
                n = ($urandom_range(7) == 0) ? $urandom_range(3, 7) : 1 << $urandom_range(5);
                queue_set(n);
                repeat ($urandom_range(3, 6))
                begin
                    if ($urandom_range(5) == 0)
                        queue_query(rand64());
                    else
                        queue_query(pick_target());
                end
                if ($urandom_range(3) == 0)
                    queue_unused();
                if ($urandom_range(3) == 0)
                begin
                    queue_append(rand64(), rand64());
                    queue_query(pick_target());
                end
            end
            wait_drained();
        end

        // hold off the receiver while appends keep coming, then pause for the backlog
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        queue_set(32);
        repeat (6)
            queue_query(pick_target());
        wait_drained();

        repeat (20) @(negedge clk);
        $display("Run covered %0d requests and %0d results over %0d cycles",
                 n_accepted, n_results, cycles);
        $display("Statuses: ok %0d, invalid %0d, bad count %0d, member %0d, none %0d, full %0d",
                 status_hits[STATUS_OK], status_hits[STATUS_INVALID],
                 status_hits[STATUS_BAD_COUNT], status_hits[STATUS_MEMBER],
                 status_hits[STATUS_NO_STRADDLE], status_hits[STATUS_FULL]);
        if (n_errors == 0 && expected_answers.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
